// ===== hdl/dsse_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dsse_pkg;

	localparam int MAX_COLS    = 2048;
	localparam int MAX_ROWS    = 4096;
	localparam int SAMPLE_BITS = 16;
	localparam int COL_BITS    = $clog2(MAX_COLS);
	localparam int ROW_BITS    = $clog2(MAX_ROWS);

	localparam int IMG_COLS_W  = 12;
	localparam int IMG_ROWS_W  = 13;
	localparam int THRESH_W    = 15;
	localparam int OCTAVE_W    = 3;
	localparam int KEY_COL_W   = 18;
	localparam int KEY_ROW_W   = 19;
	localparam int RESP_W      = 15;

	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COLS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CONTRAST_THR = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_INDEX = 2'd3;

	// result queue: room for everything in flight plus a full-rate backlog
	localparam int OUT_DEPTH   = 8;
	localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);

	// one sample per layer, [0] below, [1] centre, [2] above
	typedef logic [2:0][SAMPLE_BITS-1:0] triple_t;

	typedef struct packed {
		logic                valid;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
	} pos_t;

	// line store word
	typedef struct packed {
		triple_t near;
		triple_t far;
	} line_t;

	// new window column, top row first
	typedef struct packed {
		triple_t far;
		triple_t near;
		triple_t cur;
	} column_t;

	typedef struct packed {
		logic                valid;
		logic                hit;
		logic                is_max;
		logic [RESP_W-1:0]   response;
		logic [COL_BITS-1:0] col;
		logic [ROW_BITS-1:0] row;
	} det_t;

	typedef struct packed {
		logic [KEY_COL_W-1:0] key_col;
		logic [KEY_ROW_W-1:0] key_row;
		logic                 is_maximum;
		logic [RESP_W-1:0]    response;
	} key_t;

endpackage

`default_nettype wire

// ===== hdl/dog_scale_space_extrema.sv =====
`timescale 1ns / 1ps
`default_nettype none

// 3x3x3 difference-of-Gaussian extremum detector. Takes one raster-order pixel beat per
// clock while in_ready is high, carrying the below/centre/above layer samples (signed
// Q1.15), and reports a keypoint for the window centre one row up and one column left
// when it is interior, |centre| >= contrast_threshold, and it is strictly above or
// below all 26 neighbours. Sustained rate, while in_ready stays high, is one pixel per
// clock, limited by the single line-store RAM, which takes one read and one write-back
// each cycle; a result passes the line-store, window and detection registers and then
// the output queue, where up to 8 results wait. start_of_frame restarts the position at
// (0,0); the position also wraps after the last pixel. Coordinates are shifted left by
// octave_index. Write configuration only while no beats are in flight.
module dog_scale_space_extrema
	import dsse_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_valid,
	output logic                        cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire logic [SAMPLE_BITS-1:0] dog_below,
	input  wire logic [SAMPLE_BITS-1:0] dog_center,
	input  wire logic [SAMPLE_BITS-1:0] dog_above,
	input  wire logic                   start_of_frame,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output logic [KEY_COL_W-1:0]        key_col,
	output logic [KEY_ROW_W-1:0]        key_row,
	output logic                        is_maximum,
	output logic [RESP_W-1:0]           response
);

	localparam int CMP_W = (COL_BITS + 1 > IMG_COLS_W) ? COL_BITS + 1 : IMG_COLS_W;

	logic [IMG_COLS_W-1:0] image_cols_q;
	logic [IMG_ROWS_W-1:0] image_rows_q;
	logic [THRESH_W-1:0]   threshold_q;
	logic [OCTAVE_W-1:0]   octave_q;
	logic                  run_q;

	logic [COL_BITS-1:0]   col_q;
	logic [ROW_BITS-1:0]   row_q;

	logic [CMP_W-1:0]      cols_ext;
	logic [COL_BITS:0]     cols_eff;
	logic [IMG_ROWS_W-1:0] rows_eff;
	logic [COL_BITS-1:0]   col_raw;
	logic [ROW_BITS-1:0]   row_raw;
	logic [COL_BITS-1:0]   col_cur;
	logic [ROW_BITS-1:0]   row_cur;
	logic [COL_BITS:0]     col_inc;
	logic [IMG_ROWS_W-1:0] row_inc;

	logic                  in_accept;
	pos_t                  pos_in;
	triple_t               cur_in;
	pos_t                  pos_s1;
	logic                  pos_valid_s2;
	column_t               col_s1;
	det_t                  det_s3;
	key_t                  key_w;
	key_t                  key_r;
	logic [OUT_PTR_W:0]    fifo_count;
	logic [OUT_PTR_W+1:0]  pending;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_cols_q <= IMG_COLS_W'(640);
			image_rows_q <= IMG_ROWS_W'(480);
			threshold_q  <= THRESH_W'(229);
			octave_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_IMAGE_COLS:   image_cols_q <= cfg_data[IMG_COLS_W-1:0];
				CFG_IMAGE_ROWS:   image_rows_q <= cfg_data[IMG_ROWS_W-1:0];
				CFG_CONTRAST_THR: threshold_q  <= cfg_data[THRESH_W-1:0];
				CFG_OCTAVE_INDEX: octave_q     <= cfg_data[OCTAVE_W-1:0];
				default: ;
			endcase
		end
	end

	// size clamps
	always_comb begin
		cols_ext = CMP_W'(image_cols_q);
		if (cols_ext < CMP_W'(3)) begin
			cols_eff = (COL_BITS+1)'(3);
		end else if (cols_ext > CMP_W'(MAX_COLS)) begin
			cols_eff = (COL_BITS+1)'(MAX_COLS);
		end else begin
			cols_eff = cols_ext[COL_BITS:0];
		end
		if (image_rows_q < IMG_ROWS_W'(3)) begin
			rows_eff = IMG_ROWS_W'(3);
		end else if (image_rows_q > IMG_ROWS_W'(MAX_ROWS)) begin
			rows_eff = IMG_ROWS_W'(MAX_ROWS);
		end else begin
			rows_eff = image_rows_q;
		end
	end

	// position of the current beat
	always_comb begin
		col_raw = start_of_frame ? '0 : col_q;
		row_raw = start_of_frame ? '0 : row_q;
		col_cur = ((COL_BITS+1)'(col_raw) >= cols_eff) ? '0 : col_raw;
		row_cur = (IMG_ROWS_W'(row_raw) >= rows_eff) ? '0 : row_raw;
		col_inc = (COL_BITS+1)'(col_cur) + 1'b1;
		row_inc = IMG_ROWS_W'(row_cur) + 1'b1;
	end

	assign pending   = (OUT_PTR_W+2)'(fifo_count) + (OUT_PTR_W+2)'(pos_s1.valid)
		+ (OUT_PTR_W+2)'(det_s3.valid) + (OUT_PTR_W+2)'(pos_valid_s2);
	assign in_ready  = run_q && (pending < (OUT_PTR_W+2)'(OUT_DEPTH));
	assign in_accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			col_q <= '0;
			row_q <= '0;
		end else begin
			run_q <= 1'b1;
			if (in_accept) begin
				if (col_inc >= cols_eff) begin
					col_q <= '0;
					row_q <= (row_inc >= rows_eff) ? '0 : row_inc[ROW_BITS-1:0];
				end else begin
					col_q <= col_inc[COL_BITS-1:0];
					row_q <= row_cur;
				end
			end
		end
	end

	assign pos_in.valid = in_accept;
	assign pos_in.col   = col_cur;
	assign pos_in.row   = row_cur;
	assign cur_in       = {dog_above, dog_center, dog_below};

	dsse_line_buf u_line_buf (
		.clk    (clk),
		.arst_n (arst_n),
		.pos_in (pos_in),
		.cur_in (cur_in),
		.pos_s1 (pos_s1),
		.col_s1 (col_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_valid_s2 <= 1'b0;
		end else begin
			pos_valid_s2 <= pos_s1.valid;
		end
	end

	dsse_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.pos_s1    (pos_s1),
		.col_s1    (col_s1),
		.threshold (threshold_q),
		.det_s3    (det_s3)
	);

	assign key_w.key_col    = (KEY_COL_W'(det_s3.col) - 1'b1) << octave_q;
	assign key_w.key_row    = (KEY_ROW_W'(det_s3.row) - 1'b1) << octave_q;
	assign key_w.is_maximum = det_s3.is_max;
	assign key_w.response   = det_s3.response;

	dsse_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (det_s3.valid && det_s3.hit),
		.wdata  (key_w),
		.pop    (out_ready),
		.valid  (out_valid),
		.rdata  (key_r),
		.count  (fifo_count)
	);

	assign key_col    = key_r.key_col;
	assign key_row    = key_r.key_row;
	assign is_maximum = key_r.is_maximum;
	assign response   = key_r.response;

endmodule

`default_nettype wire

// ===== hdl/dsse_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsse_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns old contents on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== hdl/dsse_line_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsse_line_buf
	import dsse_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire pos_t    pos_in,
	input  wire triple_t cur_in,
	output pos_t         pos_s1,
	output column_t      col_s1
);

	pos_t    pos_s1_q;
	triple_t cur_s1;
	logic    fwd_s1;
	line_t   fwd_data_s1;
	logic [$bits(line_t)-1:0] ram_rdata;
	line_t   rd_line;
	line_t   wr_line;
	logic    wr_en;

	assign wr_en   = pos_s1_q.valid;
	assign rd_line = fwd_s1 ? fwd_data_s1 : line_t'(ram_rdata);

	// rows shift down one line
	assign wr_line.near = cur_s1;
	assign wr_line.far  = rd_line.near;

	dsse_ram #(
		.WIDTH ($bits(line_t)),
		.DEPTH (MAX_COLS)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (pos_s1_q.col),
		.wdata (wr_line),
		.re    (pos_in.valid),
		.raddr (pos_in.col),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s1_q <= '0;
			fwd_s1   <= 1'b0;
		end else begin
			pos_s1_q <= pos_in;
			if (pos_in.valid) begin
				fwd_s1 <= wr_en && (pos_s1_q.col == pos_in.col);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pos_in.valid) begin
			cur_s1      <= cur_in;
			fwd_data_s1 <= wr_line;
		end
	end

	assign pos_s1      = pos_s1_q;
	assign col_s1.far  = rd_line.far;
	assign col_s1.near = rd_line.near;
	assign col_s1.cur  = cur_s1;

endmodule

`default_nettype wire

// ===== hdl/dsse_window.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsse_window
	import dsse_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire pos_t                pos_s1,
	input  wire column_t             col_s1,
	input  wire logic [THRESH_W-1:0] threshold,
	output det_t                     det_s3
);

	localparam logic [SAMPLE_BITS:0] RESP_MAX = (SAMPLE_BITS+1)'((1 << RESP_W) - 1);

	// [layer][row: 0 top][col: 2 newest]
	logic signed [SAMPLE_BITS-1:0] win_q [3][3][3];
	pos_t  pos_s2;
	det_t  det_s3_q;

	logic                          gt_all;
	logic                          lt_all;
	logic signed [SAMPLE_BITS-1:0] ctr;
	logic        [SAMPLE_BITS:0]   ctr_ext;
	logic        [SAMPLE_BITS:0]   mag;
	logic                          interior;
	det_t                          det_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < 3; l++) begin
				for (int i = 0; i < 3; i++) begin
					for (int j = 0; j < 3; j++) begin
						win_q[l][i][j] <= '0;
					end
				end
			end
		end else if (pos_s1.valid) begin
			for (int l = 0; l < 3; l++) begin
				for (int i = 0; i < 3; i++) begin
					win_q[l][i][0] <= win_q[l][i][1];
					win_q[l][i][1] <= win_q[l][i][2];
				end
				win_q[l][0][2] <= $signed(col_s1.far[l]);
				win_q[l][1][2] <= $signed(col_s1.near[l]);
				win_q[l][2][2] <= $signed(col_s1.cur[l]);
			end
		end
	end

	always_comb begin
		gt_all = 1'b1;
		lt_all = 1'b1;
		ctr    = win_q[1][1][1];
		for (int l = 0; l < 3; l++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					if (!(l == 1 && i == 1 && j == 1)) begin
						if (ctr <= win_q[l][i][j]) begin
							gt_all = 1'b0;
						end
						if (ctr >= win_q[l][i][j]) begin
							lt_all = 1'b0;
						end
					end
				end
			end
		end
		ctr_ext  = {ctr[SAMPLE_BITS-1], ctr};
		mag      = ctr[SAMPLE_BITS-1] ? (SAMPLE_BITS+1)'(-ctr_ext) : ctr_ext;
		interior = (pos_s2.col >= COL_BITS'(2)) && (pos_s2.row >= ROW_BITS'(2));

		det_d.valid    = pos_s2.valid;
		det_d.hit      = pos_s2.valid && interior && (gt_all || lt_all)
			&& (mag >= (SAMPLE_BITS+1)'(threshold));
		det_d.is_max   = gt_all;
		det_d.response = (mag > RESP_MAX) ? RESP_MAX[RESP_W-1:0] : mag[RESP_W-1:0];
		det_d.col      = pos_s2.col;
		det_d.row      = pos_s2.row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_s2   <= '0;
			det_s3_q <= '0;
		end else begin
			pos_s2   <= pos_s1;
			det_s3_q <= det_d;
		end
	end

	assign det_s3 = det_s3_q;

endmodule

`default_nettype wire

// ===== hdl/dsse_out_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsse_out_fifo
	import dsse_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire key_t             wdata,
	input  wire logic             pop,
	output logic                  valid,
	output key_t                  rdata,
	output logic [OUT_PTR_W:0]    count
);

	key_t                 mem_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_PTR_W:0]   count_q;
	logic                 do_pop;

	assign valid  = (count_q != '0);
	assign do_pop = pop && valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rdata = mem_q[rd_ptr_q];
	assign count = count_q;

endmodule

`default_nettype wire

// ===== hdl/dsse_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsse_checker
	import dsse_pkg::*;
(
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [KEY_COL_W-1:0]   key_col,
	input wire logic [KEY_ROW_W-1:0]   key_row,
	input wire logic                   is_maximum,
	input wire logic [RESP_W-1:0]      response
);

	// a stalled result beat stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(key_col) && $stable(key_row)
			&& $stable(is_maximum) && $stable(response))
		else $error("result beat changed while stalled");

	// nothing comes out of reset
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid && !in_ready)
		else $error("beat shown during reset");

	// a result after an empty queue follows its pixel beat by the pipeline depth
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("result without matching pixel beat");

	// with no result waiting the input must not stall
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && $past(arst_n) |-> in_ready)
		else $error("input stalled with empty output");

endmodule

bind dog_scale_space_extrema dsse_checker u_dsse_checker (.*);

`default_nettype wire
